FILE: src/tpt_pkg.sv
// ---------------------------------------------------------------------------
// tpt_pkg: shared types and constants for the transfer progress tracker
// Event codes, phase codes, field widths and the divider response bundle.
// ---------------------------------------------------------------------------
package tpt_pkg;

  // Width of offsets and sizes
  localparam int SIZE_WIDTH = 32;
  // Width of the percentage field
  localparam int PCT_W = 7;
  // Width of written * 100 (100 fits in 7 bits)
  localparam int NUM_W = SIZE_WIDTH + PCT_W;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  // Event codes
  localparam logic [2:0] EV_RESET    = 3'd0;
  localparam logic [2:0] EV_STARTED  = 3'd1;
  localparam logic [2:0] EV_PROGRESS = 3'd2;
  localparam logic [2:0] EV_PENDING  = 3'd3;
  localparam logic [2:0] EV_STOPPED  = 3'd4;

  // Phase codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_RUNNING = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;
  localparam logic [1:0] PH_FAILED  = 2'd3;

  // Divider result bundle
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: src/tpt_if.sv
// ---------------------------------------------------------------------------
// tpt_if: valid/ready channels of the transfer progress tracker
// Event channel into the block and status channel out of it.
// ---------------------------------------------------------------------------
interface tpt_in_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     req_type;
  logic [tpt_pkg::SIZE_WIDTH-1:0] chunk_offset;
  logic [tpt_pkg::SIZE_WIDTH-1:0] image_total;
  logic                           stop_ok;

  modport source (output valid, output req_type, output chunk_offset,
                  output image_total, output stop_ok, input ready);
  modport sink   (input valid, input req_type, input chunk_offset,
                  input image_total, input stop_ok, output ready);
endinterface

interface tpt_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     phase_now;
  logic [tpt_pkg::PCT_W-1:0]      percent_done;
  logic                           busy_flag;
  logic [tpt_pkg::SIZE_WIDTH-1:0] written_now;
  logic [tpt_pkg::SIZE_WIDTH-1:0] total_now;

  modport source (output valid, output phase_now, output percent_done,
                  output busy_flag, output written_now, output total_now,
                  input ready);
  modport sink   (input valid, input phase_now, input percent_done,
                  input busy_flag, input written_now, input total_now,
                  output ready);
endinterface

FILE: src/tpt_div.sv
// ---------------------------------------------------------------------------
// tpt_div: restoring divider for the progress percentage
// Produces a 7-bit quotient, one bit per cycle, with a single
// subtract-and-compare unit. The caller guarantees quotient < 128.
// ---------------------------------------------------------------------------
module tpt_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tpt_pkg::NUM_W-1:0]      num,
  input  logic [tpt_pkg::SIZE_WIDTH-1:0] den,
  output tpt_pkg::div_rsp_t              rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [2:0]                   cnt_r, cnt_nxt;
  logic [tpt_pkg::NUM_W-1:0]    rem_r, rem_nxt;
  logic [tpt_pkg::NUM_W-1:0]    dsh_r, dsh_nxt;
  logic [tpt_pkg::PCT_W-1:0]    q_r, q_nxt;
  logic                         fits;

  // Compare remainder against the shifted divisor
  assign fits = (rem_r >= dsh_r);

  // Sequence: load, then one quotient bit per cycle, MSB first
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'(tpt_pkg::PCT_W - 1);
      rem_nxt  = num;
      dsh_nxt  = tpt_pkg::NUM_W'(den) << (tpt_pkg::PCT_W - 1);
      q_nxt    = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = {q_r[tpt_pkg::PCT_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers hold without reset
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

FILE: src/transfer_progress_tracker.sv
// ---------------------------------------------------------------------------
// transfer_progress_tracker: image transfer phase and progress tracker
// Applies each event to phase, total and written high-water mark, then
// reports the new status with a percentage from its serial divider.
// ---------------------------------------------------------------------------
//  port     | dir | kind                | beat
//  in_ch    | in  | valid/ready sink    | one event
//  out_ch   | out | valid/ready source  | one status per event
//
//  An event goes from accept through the calc step (and the range check
//  if used) to hand-off when no division is needed, and via the 7-step
//  restoring divider, which sets the pace. One event is in work at a time;
//  in_ch.ready is high while the sequencer waits for an event, also while
//  a result beat still waits in the output register. rst_n is synchronous
//  and clears phase, total and written. A stalled out_ch holds the
//  sequencer in its hand-off step.
// ---------------------------------------------------------------------------
module transfer_progress_tracker (
  input logic      clk,
  input logic      rst_n,
  tpt_in_if.sink   in_ch,
  tpt_out_if.source out_ch
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;

  logic [2:0]                     st_r, st_nxt;
  logic [1:0]                     phase_r, phase_nxt;
  logic [tpt_pkg::SIZE_WIDTH-1:0] total_r, total_nxt;
  logic [tpt_pkg::SIZE_WIDTH-1:0] written_r, written_nxt;
  logic [tpt_pkg::NUM_W-1:0]      num_r, num_nxt;
  logic [tpt_pkg::PCT_W-1:0]      pct_r, pct_nxt;
  logic                           div_start;
  tpt_pkg::div_rsp_t              div_rsp;

  logic                           out_valid_r, out_valid_nxt;
  logic [1:0]                     out_phase_r;
  logic [tpt_pkg::PCT_W-1:0]      out_pct_r;
  logic                           out_busy_r;
  logic [tpt_pkg::SIZE_WIDTH-1:0] out_written_r;
  logic [tpt_pkg::SIZE_WIDTH-1:0] out_total_r;

  logic                           in_fire;
  logic                           out_load;
  logic [tpt_pkg::SIZE_WIDTH-1:0] prog_total;
  logic [tpt_pkg::SIZE_WIDTH-1:0] prog_max;

  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (st_r == ST_PUSH) && (!out_valid_r || out_ch.ready);

  // Progress event: new total if given, keep the high-water mark
  assign prog_total = (in_ch.image_total != '0) ? in_ch.image_total : total_r;
  assign prog_max   = (in_ch.chunk_offset > written_r) ? in_ch.chunk_offset : written_r;

  // Apply one event to the tracker state
  always_comb begin
    phase_nxt   = phase_r;
    total_nxt   = total_r;
    written_nxt = written_r;
    if (in_fire) begin
      unique case (in_ch.req_type)
        tpt_pkg::EV_RESET: begin
          phase_nxt   = tpt_pkg::PH_IDLE;
          total_nxt   = '0;
          written_nxt = '0;
        end
        tpt_pkg::EV_STARTED: begin
          phase_nxt   = tpt_pkg::PH_RUNNING;
          total_nxt   = '0;
          written_nxt = '0;
        end
        tpt_pkg::EV_PROGRESS: begin
          phase_nxt = tpt_pkg::PH_RUNNING;
          total_nxt = prog_total;
          if (prog_total != '0 && prog_max > prog_total) begin
            written_nxt = prog_total;
          end else begin
            written_nxt = prog_max;
          end
        end
        tpt_pkg::EV_PENDING: begin
          phase_nxt = tpt_pkg::PH_DONE;
          if (total_r != '0) begin
            written_nxt = total_r;
          end
        end
        tpt_pkg::EV_STOPPED: begin
          if (phase_r != tpt_pkg::PH_DONE) begin
            phase_nxt = in_ch.stop_ok ? tpt_pkg::PH_DONE : tpt_pkg::PH_FAILED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer: scale, range check, divide, hand off
  always_comb begin
    st_nxt    = st_r;
    num_nxt   = num_r;
    pct_nxt   = pct_r;
    div_start = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          st_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        num_nxt = (tpt_pkg::NUM_W'(written_r) << 6) + (tpt_pkg::NUM_W'(written_r) << 5)
                + (tpt_pkg::NUM_W'(written_r) << 2);
        if (phase_r == tpt_pkg::PH_DONE) begin
          pct_nxt = tpt_pkg::PCT_FULL;
          st_nxt  = ST_PUSH;
        end else if (phase_r != tpt_pkg::PH_RUNNING || total_r == '0) begin
          pct_nxt = '0;
          st_nxt  = ST_PUSH;
        end else begin
          st_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        // Saturate when the quotient would not fit in 7 bits
        if (num_r >= {total_r, {tpt_pkg::PCT_W{1'b0}}}) begin
          pct_nxt = tpt_pkg::PCT_FULL;
          st_nxt  = ST_PUSH;
        end else begin
          div_start = 1'b1;
          st_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          pct_nxt = (div_rsp.quot > tpt_pkg::PCT_FULL) ? tpt_pkg::PCT_FULL : div_rsp.quot;
          st_nxt  = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      phase_r     <= tpt_pkg::PH_IDLE;
      total_r     <= '0;
      written_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      total_r     <= total_nxt;
      written_r   <= written_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    pct_r <= pct_nxt;
    if (out_load) begin
      out_phase_r   <= phase_r;
      out_pct_r     <= pct_r;
      out_busy_r    <= (phase_r == tpt_pkg::PH_RUNNING) || (phase_r == tpt_pkg::PH_DONE);
      out_written_r <= written_r;
      out_total_r   <= total_r;
    end
  end

  tpt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (total_r),
    .rsp   (div_rsp)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.phase_now    = out_phase_r;
  assign out_ch.percent_done = out_pct_r;
  assign out_ch.busy_flag    = out_busy_r;
  assign out_ch.written_now  = out_written_r;
  assign out_ch.total_now    = out_total_r;

  // Checks
  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> st_r == ST_CALC)
    else $error("accepted event did not enter the calc step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> st_r == ST_DIV)
    else $error("divider finished outside the divide step");

  a_written_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == tpt_pkg::PH_RUNNING && total_r != '0) |-> written_r <= total_r)
    else $error("written exceeds a known total while running");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pct_r <= tpt_pkg::PCT_FULL)
    else $error("percentage above 100");

  a_state_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |=> ($stable(phase_r) && $stable(written_r) && $stable(total_r)))
    else $error("tracker state changed while an event was in work");

endmodule

FILE: tb/tpt_status_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tpt_status_checker: status prediction and compare for the tracker
// Watches the event and status channels, keeps its own phase, total and
// written mark, predicts one status per accepted event and compares every
// status beat against the oldest prediction in order.
// ---------------------------------------------------------------------------
module tpt_status_checker
  import tpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tpt_in_if           ev_ch,
  tpt_out_if          st_ch,
  output int unsigned err_count,
  output int unsigned open_count
);

  typedef struct packed {
    logic [1:0]            phase;
    logic [PCT_W-1:0]      pct;
    logic                  busy;
    logic [SIZE_WIDTH-1:0] written;
    logic [SIZE_WIDTH-1:0] total;
  } status_t;

  // Shadow of the tracker state
  logic [1:0]            phase_sh;
  logic [SIZE_WIDTH-1:0] total_sh;
  logic [SIZE_WIDTH-1:0] written_sh;

  status_t status_q[$];

  initial begin
    err_count  = 0;
    open_count = 0;
  end

  task automatic report(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Percentage after an event; the product is kept at full width
  function automatic logic [PCT_W-1:0] percent_for(input logic [1:0] ph,
                                                   input logic [SIZE_WIDTH-1:0] wr,
                                                   input logic [SIZE_WIDTH-1:0] tot);
    logic [NUM_W-1:0] ratio;
    if (ph == PH_DONE) return PCT_FULL;
    if (ph != PH_RUNNING || tot == '0) return '0;
    ratio = (NUM_W'(wr) * NUM_W'(PCT_FULL)) / NUM_W'(tot);
    return (ratio > NUM_W'(PCT_FULL)) ? PCT_FULL : ratio[PCT_W-1:0];
  endfunction

  // Apply one event to the shadow state and build the status it yields
  function automatic status_t apply_event(input logic [2:0] kind,
                                          input logic [SIZE_WIDTH-1:0] offs,
                                          input logic [SIZE_WIDTH-1:0] tot,
                                          input logic ok);
    status_t st;
    case (kind)
      EV_RESET: begin
        phase_sh   = PH_IDLE;
        total_sh   = '0;
        written_sh = '0;
      end
      EV_STARTED: begin
        phase_sh   = PH_RUNNING;
        total_sh   = '0;
        written_sh = '0;
      end
      EV_PROGRESS: begin
        phase_sh = PH_RUNNING;
        if (tot != '0) total_sh = tot;
        if (offs > written_sh) written_sh = offs;
        if (total_sh != '0 && written_sh > total_sh) written_sh = total_sh;
      end
      EV_PENDING: begin
        phase_sh = PH_DONE;
        if (total_sh != '0) written_sh = total_sh;
      end
      EV_STOPPED: begin
        if (phase_sh != PH_DONE) phase_sh = ok ? PH_DONE : PH_FAILED;
      end
      default: ; // unused codes leave the state alone
    endcase
    st.phase   = phase_sh;
    st.pct     = percent_for(phase_sh, written_sh, total_sh);
    st.busy    = (phase_sh == PH_RUNNING) || (phase_sh == PH_DONE);
    st.written = written_sh;
    st.total   = total_sh;
    return st;
  endfunction

  // Predict on each event beat, compare on each status beat
  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      phase_sh   = PH_IDLE;
      total_sh   = '0;
      written_sh = '0;
      status_q.delete();
    end else begin
      if (ev_ch.valid && ev_ch.ready)
        status_q.push_back(apply_event(ev_ch.req_type, ev_ch.chunk_offset,
                                       ev_ch.image_total, ev_ch.stop_ok));
      if (st_ch.valid && st_ch.ready) begin
        if (status_q.size() == 0) begin
          report("status beat with no event waiting");
        end else begin
          want = status_q.pop_front();
          if (st_ch.phase_now !== want.phase)
            report($sformatf("phase_now %0d, want %0d", st_ch.phase_now, want.phase));
          if (st_ch.percent_done !== want.pct)
            report($sformatf("percent_done %0d, want %0d", st_ch.percent_done, want.pct));
          if (st_ch.busy_flag !== want.busy)
            report($sformatf("busy_flag %0b, want %0b", st_ch.busy_flag, want.busy));
          if (st_ch.written_now !== want.written)
            report($sformatf("written_now %h, want %h", st_ch.written_now, want.written));
          if (st_ch.total_now !== want.total)
            report($sformatf("total_now %h, want %h", st_ch.total_now, want.total));
        end
      end
    end
    open_count <= status_q.size();
  end

endmodule

FILE: tb/tb_transfer_progress_tracker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_transfer_progress_tracker: testbench for the transfer progress tracker
// Drives directed and random transfer event sequences with random gaps and
// status back-pressure, including a long receiver hold-off and a full
// drain pause; the checker predicts and compares every status beat.
// ---------------------------------------------------------------------------
module tb_transfer_progress_tracker;
  import tpt_pkg::*;

  localparam int          EVENT_TARGET = 1550;
  localparam int          CYCLE_LIMIT  = 800000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 400;
  // Highest value of the event field; codes above EV_STOPPED are unused
  localparam logic [2:0]  EV_LAST      = 3'd7;

  logic clk;
  logic rst_n;

  tpt_in_if  in_bus ();
  tpt_out_if out_bus ();

  int unsigned err_count;
  int unsigned open_count;
  int          events_sent;
  int          cycle_count;
  int          rx_hold_req;
  bit          calm;

  transfer_progress_tracker u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  tpt_status_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_ch      (in_bus),
    .st_ch      (out_bus),
    .err_count  (err_count),
    .open_count (open_count)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Status receiver: random stalls, plus a long hold-off on request
  initial begin
    int n;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
        out_bus.ready <= 1'b0;
        while (n > 0) begin
          @(posedge clk);
          n--;
        end
        out_bus.ready <= 1'b1;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_bus.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Offer one event beat and hold it until accepted
  task automatic send_event(input logic [2:0] kind,
                            input logic [SIZE_WIDTH-1:0] offs,
                            input logic [SIZE_WIDTH-1:0] tot,
                            input logic ok);
    int n;
    n = pick_gap();
    if (n > 0) begin
      in_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.req_type     <= kind;
    in_bus.chunk_offset <= offs;
    in_bus.image_total  <= tot;
    in_bus.stop_ok      <= ok;
    do @(posedge clk); while (!in_bus.ready);
    events_sent++;
  endtask

  // Wait until every predicted status has come back
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
  endtask

  task automatic send_noise();
    logic [SIZE_WIDTH-1:0] tot;
    tot = ($urandom_range(0, 3) == 0) ? '0 : SIZE_WIDTH'($urandom);
    send_event(3'($urandom_range(0, EV_LAST)), SIZE_WIDTH'($urandom), tot,
               1'($urandom_range(0, 1)));
  endtask

  // One well-formed transfer with random content and a random ending
  task automatic run_transfer();
    logic [SIZE_WIDTH-1:0] tot, offs, step, tot_field;
    int                    n;
    if ($urandom_range(0, 7) != 0) send_event(EV_STARTED, '0, '0, 1'b0);
    case ($urandom_range(0, 3))
      0:       tot = SIZE_WIDTH'($urandom_range(1, 1000));
      1:       tot = SIZE_WIDTH'($urandom);
      2:       tot = {SIZE_WIDTH{1'b1}} - SIZE_WIDTH'($urandom_range(0, 255));
      default: tot = '0;
    endcase
    offs = '0;
    n = $urandom_range(1, 8);
    repeat (n) begin
      step = (tot == '0) ? SIZE_WIDTH'($urandom)
                         : SIZE_WIDTH'($urandom_range(0, tot / 4 + 1));
      offs = ($urandom_range(0, 7) == 0) ? SIZE_WIDTH'($urandom) : offs + step;
      case ($urandom_range(0, 7))
        0, 1:    tot_field = '0;
        2:       tot_field = SIZE_WIDTH'($urandom_range(1, 5000));
        default: tot_field = tot;
      endcase
      send_event(EV_PROGRESS, offs, tot_field, 1'($urandom_range(0, 1)));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: send_event(EV_PENDING, SIZE_WIDTH'($urandom),
                                SIZE_WIDTH'($urandom), 1'($urandom_range(0, 1)));
      5, 6, 7:       send_event(EV_STOPPED, SIZE_WIDTH'($urandom),
                                SIZE_WIDTH'($urandom), 1'($urandom_range(0, 1)));
      8: begin
        send_event(EV_STOPPED, '0, '0, 1'($urandom_range(0, 1)));
        send_event(EV_STOPPED, '0, '0, 1'($urandom_range(0, 1)));
      end
      default: ; // abandon the transfer mid-way
    endcase
  endtask

  // Stimulus
  initial begin
    logic [2:0] code;
    bit         hold_done;
    bit         pause_done;
    events_sent         = 0;
    rx_hold_req         = 0;
    calm                = 1'b0;
    hold_done           = 1'b0;
    pause_done          = 1'b0;
    rst_n              <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.req_type     <= EV_RESET;
    in_bus.chunk_offset <= '0;
    in_bus.image_total  <= '0;
    in_bus.stop_ok      <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every event, unused codes
    send_event(EV_RESET, '0, '0, 1'b0);
    send_event(EV_PROGRESS, {SIZE_WIDTH{1'b1}}, '0, 1'b0);   // no total known yet
    send_event(EV_STARTED, {SIZE_WIDTH{1'b1}}, {SIZE_WIDTH{1'b1}}, 1'b1);
    send_event(EV_PROGRESS, 32'd50, 32'd200, 1'b0);
    send_event(EV_PROGRESS, 32'd10, '0, 1'b0);               // backwards offset
    send_event(EV_PROGRESS, {SIZE_WIDTH{1'b1}}, {SIZE_WIDTH{1'b1}}, 1'b0);
    send_event(EV_PROGRESS, 32'hFFFF_FFFE, '0, 1'b0);
    send_event(EV_PROGRESS, 32'd1000, 32'd100, 1'b0);        // total shrinks, clamp
    send_event(EV_STOPPED, '0, '0, 1'b0);                    // failed
    send_event(EV_STOPPED, '0, '0, 1'b1);                    // failed to done
    send_event(EV_STOPPED, '0, '0, 1'b0);                    // ignored once done
    send_event(EV_PENDING, '0, '0, 1'b0);
    for (code = EV_STOPPED + 3'd1; code != 3'd0; code++)
      send_event(code, {SIZE_WIDTH{1'b1}}, {SIZE_WIDTH{1'b1}}, 1'b1);
    send_event(EV_STARTED, '0, '0, 1'b0);
    send_event(EV_PENDING, '0, '0, 1'b0);                    // done with no total
    send_event(EV_STARTED, '0, '0, 1'b0);
    send_event(EV_PROGRESS, 32'd3, 32'd7, 1'b0);
    send_event(EV_PROGRESS, 32'd1, {SIZE_WIDTH{1'b1}}, 1'b0);
    send_event(EV_STOPPED, '0, '0, 1'b1);
    send_event(EV_RESET, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1);

    // Random transfers and noise
    while (events_sent < EVENT_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end else begin
        run_transfer();
      end

      // Long receiver hold-off while events keep coming
      if (!hold_done && events_sent >= 500) begin
        hold_done   = 1'b1;
        calm        = 1'b1;
        rx_hold_req = HOLD_CYCLES;
        repeat (3) run_transfer();
      end

      // Sender pause until every status is back
      if (!pause_done && events_sent >= 1000) begin
        pause_done = 1'b1;
        drain();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
